// ----- rtl/core/int_to_decimal_ascii_assert.svh -----
// Assertion macros for the decimal text converter.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Check a property while out of reset.
`define ITDA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define ITDA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/itda_pkg.sv -----
`default_nettype none

package itda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int CHAR_WIDTH  = 7;

    localparam int DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_W  = $clog2(DIGITS + 1);

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift_digit;
    } t_bcd_ctrl;

endpackage

`default_nettype wire

// ----- rtl/core/int_to_decimal_ascii.sv -----
// After the input transaction, a conversion pass feeds the magnitude through the
// bit-serial double dabble shift register, one magnitude bit per cycle; leading
// zeros are then dropped, and the sign (when negative) precedes the digits. A new
// number is taken only after the last character of the previous one is issued.
// One character per cycle once output starts, while the receiver does not stall.
// Reset: synchronous, active low; returns to idle and drops any pending character.
`default_nettype none

module int_to_decimal_ascii
    import itda_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [FIELD_WIDTH-1:0] i_value,
    output logic                        o_stall,
    output logic                        o_valid,
    output logic      [CHAR_WIDTH-1:0]  o_character,
    output logic                        o_last,
    input  wire logic                   i_stall
);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIG_W-1:0]       r_dig, n_dig;
    logic                   r_neg, n_neg;
    logic                   r_ovalid, n_ovalid;
    logic [CHAR_WIDTH-1:0]  r_char, n_char;
    logic                   r_last, n_last;

    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_sign;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_top_zero;
    logic [3:0]             w_top;
    t_bcd_ctrl              w_ctrl;

    assign w_raw      = i_value[VALUE_WIDTH-1:0];
    assign w_sign     = w_raw[VALUE_WIDTH-1];
    assign w_mag      = w_sign ? (~w_raw + VALUE_WIDTH'(1)) : w_raw;
    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_top_zero = (w_top == 4'd0);

    itda_bcd_shift u_bcd (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_mag       (w_mag),
        .o_top_digit (w_top)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (r_cnt == CNT_W'(0)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!w_top_zero || r_dig == DIG_W'(1)) begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_out_free && r_dig == DIG_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_neg    = r_neg;
        n_ovalid = r_ovalid && i_stall;
        n_char   = r_char;
        n_last   = r_last;
        w_ctrl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.load = 1'b1;
                    n_neg       = w_sign;
                    n_cnt       = CNT_W'(VALUE_WIDTH - 1);
                    n_dig       = DIG_W'(DIGITS);
                end
            end
            S_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_cnt         = r_cnt - CNT_W'(1);
            end
            S_SKIP: begin
                if (w_top_zero && r_dig != DIG_W'(1)) begin
                    w_ctrl.shift_digit = 1'b1;
                    n_dig              = r_dig - DIG_W'(1);
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_MINUS;
                    n_last   = 1'b0;
                end
            end
            S_DIGIT: begin
                if (w_out_free) begin
                    w_ctrl.shift_digit = 1'b1;
                    n_ovalid           = 1'b1;
                    n_char             = CHAR_ZERO + CHAR_WIDTH'(w_top);
                    n_last             = (r_dig == DIG_W'(1));
                    n_dig              = r_dig - DIG_W'(1);
                end
            end
            default: begin
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_dig    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_dig    <= n_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

`include "int_to_decimal_ascii_assert.svh"

    `ITDA_ASSERT(a_char_range,
        o_valid |-> (o_character == CHAR_MINUS) ||
                    ((o_character >= CHAR_ZERO) && (o_character <= CHAR_NINE)),
        "character outside digit and sign set")

    `ITDA_ASSERT(a_sign_not_last,
        (o_valid && o_character == CHAR_MINUS) |-> !o_last,
        "sign marked as final character")

    `ITDA_ASSERT(a_digit_count,
        (r_state == S_DIGIT || r_state == S_SKIP) |-> (r_dig != DIG_W'(0)),
        "digit counter underflow")

    `ITDA_ASSERT_ALWAYS(a_reset_idle,
        !i_rst_n |=> (r_state == S_IDLE && !o_valid),
        "not idle after reset")

endmodule

`default_nettype wire

// ----- rtl/core/itda_bcd_shift.sv -----
`default_nettype none

module itda_bcd_shift
    import itda_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire t_bcd_ctrl              i_ctrl,
    input  wire logic [VALUE_WIDTH-1:0] i_mag,
    output logic      [3:0]             o_top_digit
);

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       w_adj;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (i_ctrl.dabble) begin
            r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
        end else if (i_ctrl.shift_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ----- bench/int_to_decimal_ascii_tb.sv -----
`default_nettype none

module int_to_decimal_ascii_tb;
    import itda_pkg::*;

    typedef struct {
        logic [CHAR_WIDTH-1:0] code;
        logic                  last;
    } t_text_char;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic [FIELD_WIDTH-1:0] i_value;
    logic                   o_stall;
    logic                   o_valid;
    logic [CHAR_WIDTH-1:0]  o_character;
    logic                   o_last;
    logic                   i_stall;

    t_text_char expected_text [$];
    t_text_char head;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         mismatch_count = 0;
    int         numbers_sent;
    int         negatives_sent;
    int         chars_checked = 0;

    int_to_decimal_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void predict_decimal_text(input logic [FIELD_WIDTH-1:0] value);
        logic [VALUE_WIDTH-1:0] raw;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [3:0]             digit_buf [0:23];
        int                     n_digits;
        t_text_char             entry;
        raw       = value[VALUE_WIDTH-1:0];
        magnitude = raw[VALUE_WIDTH-1] ? -raw : raw;
        n_digits  = 0;
        do begin
            digit_buf[n_digits] = 4'(magnitude % 10);
            n_digits++;
            magnitude = magnitude / 10;
        end while (magnitude != 0 && n_digits < 24);
        if (raw[VALUE_WIDTH-1]) begin
            entry.code = CHAR_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        for (int k = n_digits - 1; k >= 0; k--) begin
            entry.code = CHAR_ZERO + digit_buf[k];
            entry.last = (k == 0);
            expected_text.push_back(entry);
        end
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] random_value();
        logic [FIELD_WIDTH-1:0] value;
        longint unsigned        lo;
        longint unsigned        hi;
        int                     n_dec;
        case ($urandom_range(0, 4))
            0: begin
                value = $urandom;
            end
            1: begin
                n_dec = $urandom_range(1, 10);
                lo    = 1;
                repeat (n_dec - 1) lo = lo * 10;
                hi    = lo * 10 - 1;
                if (n_dec == 1) lo = 0;
                if (hi > 64'd2147483647) hi = 64'd2147483647;
                value = $urandom_range(hi[31:0], lo[31:0]);
                if ($urandom_range(0, 1)) value = -value;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: value = 32'h7FFF_FFFF - $urandom_range(0, 3);
                    1: value = 32'h8000_0000 + $urandom_range(0, 3);
                    2: value = $urandom_range(0, 3);
                    default: value = 32'hFFFF_FFFF - $urandom_range(0, 3);
                endcase
            end
            3: begin
                value = 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1)) value = ~value;
            end
            default: begin
                value = $urandom_range(0, 20);
                if ($urandom_range(0, 1)) value = -value;
            end
        endcase
        return value;
    endfunction

    task automatic send_value(input logic [FIELD_WIDTH-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_decimal_text(value);
        numbers_sent++;
        if (value[VALUE_WIDTH-1]) negatives_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_value <= $urandom;
    endtask

    task automatic wait_for_drain();
        while (expected_text.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_extremes();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd9);
        send_value(-32'sd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(-32'sd100);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h8000_0001);
        send_value(32'h7FFF_FFFE);
        send_value(32'd1000000000);
        send_value(32'd999999999);
        send_value(-32'sd1000000000);
        send_value(-32'sd999999999);
        send_value(32'd1234567890);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
    endtask

    task automatic test_drain_pause();
        repeat (3) send_value(random_value());
        release_input();
        wait_for_drain();
        send_value(32'd0);
        send_value(32'h8000_0000);
        release_input();
        wait_for_drain();
    endtask

    task automatic test_random_values(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_value(random_value());
    endtask

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, o_character, o_last);
                mismatch_count++;
            end else begin
                head = expected_text.pop_front();
                if (o_character !== head.code) begin
                    $display("%0t: character mismatch: expected %h, actual %h",
                             $time, head.code, o_character);
                    mismatch_count++;
                end
                if (o_last !== head.last) begin
                    $display("%0t: last flag mismatch: expected %b, actual %b",
                             $time, head.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("%0t: timeout with %0d characters outstanding", $time, expected_text.size());
        $display("** int_to_decimal_ascii: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_value        = '0;
        tx_idle_pct    = 15;
        rx_idle_pct    = 58;
        numbers_sent   = 0;
        negatives_sent = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_drain_pause();
        test_random_values(100, 15, 58);
        test_random_values(100, 58, 15);
        test_random_values(95, 0, 0);

        release_input();
        wait_for_drain();
        repeat (60) @(posedge i_clk);
        if (expected_text.size() != 0) begin
            $display("%0t: %0d expected characters never arrived", $time, expected_text.size());
        end

        $display("Converted %0d numbers (%0d negative), %0d characters checked.",
                 numbers_sent, negatives_sent, chars_checked);
        $display("Mixes: sender-light, receiver-light and unthrottled; one full drain pause.");
        if (mismatch_count == 0 && expected_text.size() == 0) begin
            $display("** int_to_decimal_ascii: PASSED **");
        end else begin
            $display("** int_to_decimal_ascii: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/itda_pkg.sv
rtl/core/itda_bcd_shift.sv
rtl/core/int_to_decimal_ascii.sv
bench/int_to_decimal_ascii_tb.sv
